// ----- rtl/core/cyfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cyfr_pkg
// Shared types, codes and constants of the Cyfral key pulse decoder.
// ----------------------------------------------------------------------------
package cyfr_pkg;

    localparam int TICKS_W      = 24;
    localparam int PERIOD_W     = TICKS_W + 1;
    localparam int KEY_W        = 16;
    localparam int NIBBLE_W     = 4;
    localparam int BITCNT_W     = 3;

    localparam int DEFAULT_DATA_NIBBLES = 8;

    localparam logic [TICKS_W-1:0] MAX_PERIOD_RESET = 24'd14720;

    // Output queue depth; a power of two so the pointers wrap by themselves.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    // Stream packing widths, rounded up to whole bytes.
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 24;

    // Nibble codes on the line.
    localparam logic [NIBBLE_W-1:0] NIB_START_STOP = 4'b0001;
    localparam logic [NIBBLE_W-1:0] NIB_PAIR_3     = 4'b1110;
    localparam logic [NIBBLE_W-1:0] NIB_PAIR_2     = 4'b1101;
    localparam logic [NIBBLE_W-1:0] NIB_PAIR_1     = 4'b1011;
    localparam logic [NIBBLE_W-1:0] NIB_PAIR_0     = 4'b0111;

    // Operation codes of an input beat.
    localparam logic OP_PULSE   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        PHASE_START,
        PHASE_DATA,
        PHASE_STOP
    } t_phase;

    typedef struct packed {
        logic               operation;
        logic               level_high;
        logic [TICKS_W-1:0] pulse_ticks;
    } t_item;

    typedef struct packed {
        logic             key_ready;
        logic [KEY_W-1:0] key_value;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [1:0] pair;
    } t_pair;

    // Maps a one-hot-low data nibble to its two key bits.
    function automatic t_pair decode_nibble(input logic [NIBBLE_W-1:0] nib);
        t_pair p;
        p.ok   = 1'b1;
        p.pair = 2'd0;
        case (nib)
            NIB_PAIR_3: p.pair = 2'd3;
            NIB_PAIR_2: p.pair = 2'd2;
            NIB_PAIR_1: p.pair = 2'd1;
            NIB_PAIR_0: p.pair = 2'd0;
            default:    p.ok   = 1'b0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/cyfr_decoder_core.sv -----
// ----------------------------------------------------------------------------
// cyfr_decoder_core
// Frame state of the decoder; applies one registered beat per cycle.
// ----------------------------------------------------------------------------
module cyfr_decoder_core
    import cyfr_pkg::*;
#(
    parameter int DATA_NIBBLES = DEFAULT_DATA_NIBBLES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [TICKS_W-1:0] i_cfg_wr_data,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output t_result            o_result
);

    localparam int NR_W = $clog2(DATA_NIBBLES + 1);

    logic [TICKS_W-1:0]  r_period_limit;
    t_phase              r_phase,      n_phase;
    logic                r_expect_low, n_expect_low;
    logic [PERIOD_W-1:0] r_period,     n_period;
    logic [NIBBLE_W-1:0] r_nib,        n_nib;
    logic [BITCNT_W-1:0] r_bits,       n_bits;
    logic [NR_W-1:0]     r_nread,      n_nread;
    logic                r_ok,         n_ok;
    logic [KEY_W-1:0]    r_key,        n_key;
    logic                r_done,       n_done;

    logic                restart;
    logic                got;
    logic                bit_val;
    logic [PERIOD_W-1:0] sum;
    logic [NIBBLE_W-1:0] shifted;
    t_pair               dec;

    always_comb begin
        n_phase      = r_phase;
        n_expect_low = r_expect_low;
        n_period     = r_period;
        n_nib        = r_nib;
        n_bits       = r_bits;
        n_nread      = r_nread;
        n_ok         = r_ok;
        n_key        = r_key;
        n_done       = r_done;
        restart      = 1'b0;
        got          = 1'b0;
        bit_val      = 1'b0;
        sum          = r_period + {1'b0, i_item.pulse_ticks};
        shifted      = {r_nib[NIBBLE_W-2:0], 1'b0};
        dec          = decode_nibble(r_nib);

        if (i_item_valid) begin
            if (i_item.operation == OP_RESTART) begin
                restart = 1'b1;
            end else if (!r_done) begin
                if (!r_expect_low) begin
                    if (!i_item.level_high) begin
                        restart = 1'b1;
                    end else begin
                        n_period     = sum;
                        n_expect_low = 1'b1;
                        if (sum > {1'b0, r_period_limit}) begin
                            restart = 1'b1;
                        end else begin
                            got     = 1'b1;
                            bit_val = !(sum[PERIOD_W-1:1] > i_item.pulse_ticks);
                        end
                    end
                end else begin
                    if (i_item.level_high) begin
                        restart = 1'b1;
                    end else begin
                        n_period     = {1'b0, i_item.pulse_ticks};
                        n_expect_low = 1'b0;
                    end
                end

                shifted = {r_nib[NIBBLE_W-2:0], bit_val};
                dec     = decode_nibble(shifted);

                if (got) begin
                    case (r_phase)
                        PHASE_START: begin
                            n_nib = shifted;
                            if (shifted == NIB_START_STOP) begin
                                n_nib   = '0;
                                n_phase = PHASE_DATA;
                            end
                        end
                        PHASE_DATA: begin
                            n_nib  = shifted;
                            n_bits = r_bits + BITCNT_W'(1);
                            if (r_bits == BITCNT_W'(NIBBLE_W - 1)) begin
                                if (dec.ok) begin
                                    n_key = {r_key[KEY_W-3:0], dec.pair};
                                end else begin
                                    n_ok = 1'b0;
                                end
                                n_nib   = '0;
                                n_bits  = '0;
                                n_nread = r_nread + NR_W'(1);
                            end
                            if (n_nread >= NR_W'(DATA_NIBBLES)) begin
                                n_phase = PHASE_STOP;
                            end
                        end
                        PHASE_STOP: begin
                            n_nib  = shifted;
                            n_bits = r_bits + BITCNT_W'(1);
                            if (r_bits >= BITCNT_W'(NIBBLE_W - 1)) begin
                                if (shifted == NIB_START_STOP && r_ok) begin
                                    n_done = 1'b1;
                                end else begin
                                    restart = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase = PHASE_START;
                        end
                    endcase
                end
            end

            if (restart) begin
                n_phase      = PHASE_START;
                n_expect_low = 1'b0;
                n_period     = '0;
                n_nib        = '0;
                n_bits       = '0;
                n_nread      = '0;
                n_ok         = 1'b1;
                n_key        = '0;
                n_done       = 1'b0;
            end
        end

        o_result.key_ready = n_done;
        o_result.key_value = n_done ? n_key : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_limit <= MAX_PERIOD_RESET;
            r_phase        <= PHASE_START;
            r_expect_low   <= 1'b0;
            r_period       <= '0;
            r_nib          <= '0;
            r_bits         <= '0;
            r_nread        <= '0;
            r_ok           <= 1'b1;
            r_key          <= '0;
            r_done         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period_limit <= i_cfg_wr_data;
            end
            r_phase      <= n_phase;
            r_expect_low <= n_expect_low;
            r_period     <= n_period;
            r_nib        <= n_nib;
            r_bits       <= n_bits;
            r_nread      <= n_nread;
            r_ok         <= n_ok;
            r_key        <= n_key;
            r_done       <= n_done;
        end
    end

endmodule

// ----- rtl/core/cyfral_key_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// cyfral_key_pulse_decoder
// Decodes timed line pulses of a Cyfral key into a 16-bit key value.
// ----------------------------------------------------------------------------
// Data path: an accepted beat is held in the input register, decoded from
// it, and its result is written into the output queue that drives m_tdata.
// Throughput: one beat per cycle while m_tready is high; s_tready drops only
// once the four-entry output queue and the input register hold four beats.
// Reset: synchronous, active low; clears the frame state, the queue and
// restores max_bit_period to 14720 ticks.
module cyfral_key_pulse_decoder
    import cyfr_pkg::*;
#(
    parameter int DATA_NIBBLES = DEFAULT_DATA_NIBBLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: max_bit_period.
    input  logic                 i_cfg_wr_en,
    input  logic [TICKS_W-1:0]   i_cfg_wr_data,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] level_high, [24:1] pulse_ticks
    input  logic                 s_tuser,   // [0] operation
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] key_ready, [16:1] key_value
);

    // The input register holds one beat for the decode step. Every beat that
    // reaches it is decoded in the next cycle and its result written into the
    // output queue, so s_tready reserves a queue slot for it in advance.
    logic                r_in_valid;
    t_item               r_in_item;

    t_result             core_result;

    t_result             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    logic                in_take;
    logic                out_take;
    logic [QCNT_W-1:0]   pending;

    assign pending  = r_count + {{(QCNT_W-1){1'b0}}, r_in_valid};
    assign s_tready = (pending < QCNT_W'(QUEUE_DEPTH));
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = (r_count != '0);
    assign out_take = m_tvalid && m_tready;

    always_comb begin
        n_count = r_count;
        if (r_in_valid && !out_take) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!r_in_valid && out_take) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= in_take;
            r_count    <= n_count;
            if (r_in_valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.operation   <= s_tuser;
            r_in_item.level_high  <= s_tdata[0];
            r_in_item.pulse_ticks <= s_tdata[TICKS_W:1];
        end
        if (r_in_valid) begin
            r_queue[r_wr_ptr] <= core_result;
        end
    end

    cyfr_decoder_core #(
        .DATA_NIBBLES (DATA_NIBBLES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (r_in_valid),
        .i_item        (r_in_item),
        .o_result      (core_result)
    );

    // The padding bits above key_value are driven as zeros.
    assign m_tdata = {{(M_TDATA_W-KEY_W-1){1'b0}},
                      r_queue[r_rd_ptr].key_value,
                      r_queue[r_rd_ptr].key_ready};

endmodule

// ----- rtl/core/cyfr_checker.sv -----
// ----------------------------------------------------------------------------
// cyfr_checker
// Port-level checks of the Cyfral key pulse decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cyfr_checker
    import cyfr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A key value is shown only together with key_ready.
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[KEY_W:1] == '0)
        else $error("key_value not zero without key_ready");

    // The padding above key_value stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:KEY_W+1] == '0)
        else $error("m_tdata padding not zero");

    // No result appears in the cycle after reset, before any beat was taken.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // With no input being accepted and none in the input register, an empty queue stays empty.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready)
        |=> !m_tvalid)
        else $error("result beat without an input beat");

endmodule

bind cyfral_key_pulse_decoder cyfr_checker u_cyfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
